/* sv/hdufb_pkg.sv */
// shared constants and types for the half-duplex serial frame buffer
package hdufb_pkg;

  localparam int unsigned BUF_DEPTH = 128;
  localparam int unsigned AW        = $clog2(BUF_DEPTH);
  localparam int unsigned CW        = $clog2(BUF_DEPTH + 1);
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QAW       = $clog2(QDEPTH);
  localparam int unsigned QCW       = $clog2(QDEPTH + 1);

  localparam int unsigned RX_LIMIT_INT = ((BUF_DEPTH - 1) > 127) ? 127 : (BUF_DEPTH - 1);
  localparam logic [6:0]  RX_LIMIT     = 7'(RX_LIMIT_INT);

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DW    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RX_GAP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIVE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LEN = 2'd2;

  localparam logic [15:0] RX_GAP_RST    = 16'd5;
  localparam logic [15:0] ALIVE_RST     = 16'd1000;
  localparam logic [6:0]  SHORT_LEN_RST = 7'd8;

  localparam logic [2:0] ACT_RX      = 3'd0;
  localparam logic [2:0] ACT_TICK    = 3'd1;
  localparam logic [2:0] ACT_APPEND  = 3'd2;
  localparam logic [2:0] ACT_SLOT    = 3'd3;
  localparam logic [2:0] ACT_DONE    = 3'd4;
  localparam logic [2:0] ACT_RELEASE = 3'd5;

  typedef struct packed {
    logic       is_rx;
    logic       is_tick;
    logic       is_append;
    logic       is_slot;
    logic       is_done;
    logic       is_rel;
    logic [7:0] data;
  } item_t;

endpackage

/* sv/hdufb_front.sv */
// input decode and two-entry item queue
module hdufb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          action_i,
  input  logic [7:0]          data_byte_i,
  output logic                q_valid_o,
  output hdufb_pkg::item_t    q_item_o,
  input  logic                q_pop_i
);

  hdufb_pkg::item_t                  dec;
  hdufb_pkg::item_t                  slot_q [hdufb_pkg::QDEPTH];
  logic [hdufb_pkg::QAW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [hdufb_pkg::QAW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [hdufb_pkg::QCW-1:0]         cnt_q, cnt_d;
  logic                              push;

  always_comb begin
    dec      = '0;
    dec.data = data_byte_i;
    case (action_i)
      hdufb_pkg::ACT_RX:      dec.is_rx     = 1'b1;
      hdufb_pkg::ACT_TICK:    dec.is_tick   = 1'b1;
      hdufb_pkg::ACT_APPEND:  dec.is_append = 1'b1;
      hdufb_pkg::ACT_SLOT:    dec.is_slot   = 1'b1;
      hdufb_pkg::ACT_DONE:    dec.is_done   = 1'b1;
      hdufb_pkg::ACT_RELEASE: dec.is_rel    = 1'b1;
      default:                dec.data      = data_byte_i;
    endcase
  end

  assign in_stall_o = (cnt_q == hdufb_pkg::QCW'(hdufb_pkg::QDEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= dec;
    end
  end

endmodule

/* sv/hdufb_back.sv */
// frame, timer and transmit state with the shared byte store and result register
module hdufb_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [hdufb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [hdufb_pkg::CFG_DW-1:0]       cfg_data_i,
  input  logic                               q_valid_i,
  input  hdufb_pkg::item_t                   q_item_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               tx_valid_o,
  output logic [7:0]                         tx_byte_o,
  output logic                               driver_enable_o,
  output logic                               frame_ready_o,
  output logic                               short_frame_o,
  output logic [6:0]                         rx_count_o,
  output logic                               link_alive_o,
  output logic                               tx_drained_o
);

  logic [15:0]                rx_gap_q;
  logic [15:0]                alive_ticks_q;
  logic [6:0]                 short_len_q;

  logic [7:0]                 mem_q [hdufb_pkg::BUF_DEPTH];

  logic [6:0]                 rx_count_q, rx_count_d;
  logic                       closed_q, closed_d;
  logic                       short_q, short_d;
  logic [15:0]                gap_q, gap_d;
  logic [15:0]                alive_q, alive_d;
  logic [hdufb_pkg::CW-1:0]   fill_q, fill_d;
  logic [hdufb_pkg::CW-1:0]   sent_q, sent_d;
  logic [hdufb_pkg::CW-1:0]   fill_base;
  logic                       active_q, active_d;
  logic                       armed_q, armed_d;

  logic                       out_valid_q;
  logic                       tx_valid_q;
  logic [7:0]                 tx_byte_q;

  logic                       we;
  logic [hdufb_pkg::AW-1:0]   waddr;
  logic                       emit;
  logic [hdufb_pkg::AW-1:0]   raddr;

  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    rx_count_d = rx_count_q;
    closed_d   = closed_q;
    short_d    = short_q;
    gap_d      = gap_q;
    alive_d    = alive_q;
    fill_d     = fill_q;
    sent_d     = sent_q;
    active_d   = active_q;
    armed_d    = armed_q;
    we         = 1'b0;
    waddr      = '0;
    emit       = 1'b0;
    raddr      = '0;
    fill_base  = active_q ? fill_q : '0;
    if (q_pop_o) begin
      if (q_item_i.is_rx) begin
        alive_d = alive_ticks_q;
        if (!closed_q) begin
          gap_d = rx_gap_q;
          if (rx_count_q < hdufb_pkg::RX_LIMIT) begin
            we         = 1'b1;
            waddr      = hdufb_pkg::AW'(rx_count_q);
            rx_count_d = rx_count_q + 7'd1;
            if (rx_count_d == short_len_q) begin
              short_d = 1'b1;
            end
            if (rx_count_d == hdufb_pkg::RX_LIMIT) begin
              closed_d = 1'b1;
            end
          end
        end
      end else if (q_item_i.is_tick) begin
        if (gap_q != '0) begin
          gap_d = gap_q - 16'd1;
          if (gap_q == 16'd1 && rx_count_q != '0) begin
            closed_d = 1'b1;
          end
        end
        if (alive_q != '0) begin
          alive_d = alive_q - 16'd1;
        end
      end else if (q_item_i.is_append) begin
        if (!active_q) begin
          active_d = 1'b1;
          armed_d  = 1'b0;
          sent_d   = '0;
        end
        fill_d = fill_base;
        if (fill_base < hdufb_pkg::CW'(hdufb_pkg::BUF_DEPTH)) begin
          we     = 1'b1;
          waddr  = hdufb_pkg::AW'(fill_base);
          fill_d = fill_base + 1'b1;
        end
      end else if (q_item_i.is_slot) begin
        if (active_q && !armed_q) begin
          if (sent_q < fill_q) begin
            emit   = 1'b1;
            raddr  = hdufb_pkg::AW'(sent_q);
            sent_d = sent_q + 1'b1;
          end else begin
            armed_d = 1'b1;
          end
        end
      end else if (q_item_i.is_done) begin
        if (armed_q) begin
          armed_d  = 1'b0;
          active_d = 1'b0;
        end
      end else if (q_item_i.is_rel) begin
        rx_count_d = '0;
        closed_d   = 1'b0;
        short_d    = 1'b0;
        gap_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_gap_q      <= hdufb_pkg::RX_GAP_RST;
      alive_ticks_q <= hdufb_pkg::ALIVE_RST;
      short_len_q   <= hdufb_pkg::SHORT_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        hdufb_pkg::CFG_RX_GAP:    rx_gap_q      <= cfg_data_i;
        hdufb_pkg::CFG_ALIVE:     alive_ticks_q <= cfg_data_i;
        hdufb_pkg::CFG_SHORT_LEN: short_len_q   <= cfg_data_i[6:0];
        default:                  rx_gap_q      <= rx_gap_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_count_q  <= '0;
      closed_q    <= 1'b0;
      short_q     <= 1'b0;
      gap_q       <= '0;
      alive_q     <= '0;
      fill_q      <= '0;
      sent_q      <= '0;
      active_q    <= 1'b0;
      armed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rx_count_q <= rx_count_d;
      closed_q   <= closed_d;
      short_q    <= short_d;
      gap_q      <= gap_d;
      alive_q    <= alive_d;
      fill_q     <= fill_d;
      sent_q     <= sent_d;
      active_q   <= active_d;
      armed_q    <= armed_d;
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= q_item_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      tx_valid_q <= emit;
      tx_byte_q  <= emit ? mem_q[raddr] : 8'd0;
    end
  end

  // status follows the state of the item held in the result register
  assign out_valid_o     = out_valid_q;
  assign tx_valid_o      = tx_valid_q;
  assign tx_byte_o       = tx_byte_q;
  assign driver_enable_o = active_q;
  assign frame_ready_o   = closed_q;
  assign short_frame_o   = short_q;
  assign rx_count_o      = rx_count_q;
  assign link_alive_o    = (alive_q != '0);
  assign tx_drained_o    = armed_q;

endmodule

/* sv/halfduplex_uart_frame_buffer.sv */
// top level of the half-duplex serial frame buffer
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------------
//  in       | in_valid_i / in_stall_o    | action_i, data_byte_i
//  out      | out_valid_o / out_stall_i  | tx_valid_o, tx_byte_o, status flags, rx_count_o
//  cfg      | cfg_we_i                   | cfg_index_i, cfg_data_i
//
// one item per cycle sustained while out_stall_i is low; an accepted item is written into
// the two-entry queue, then popped into the result register, which shows its result
// the result register is loaded with the store read of the byte being sent
// reset clears all control state but tx_valid_o and tx_byte_o; the byte store is not cleared
// out_stall_i holds the result register, the queue then fills and raises in_stall_o
module halfduplex_uart_frame_buffer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [hdufb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [hdufb_pkg::CFG_DW-1:0]       cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [2:0]                         action_i,
  input  logic [7:0]                         data_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               tx_valid_o,
  output logic [7:0]                         tx_byte_o,
  output logic                               driver_enable_o,
  output logic                               frame_ready_o,
  output logic                               short_frame_o,
  output logic [6:0]                         rx_count_o,
  output logic                               link_alive_o,
  output logic                               tx_drained_o
);

  logic             q_valid;
  logic             q_pop;
  hdufb_pkg::item_t q_item;

  hdufb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .data_byte_i (data_byte_i),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  hdufb_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .tx_valid_o      (tx_valid_o),
    .tx_byte_o       (tx_byte_o),
    .driver_enable_o (driver_enable_o),
    .frame_ready_o   (frame_ready_o),
    .short_frame_o   (short_frame_o),
    .rx_count_o      (rx_count_o),
    .link_alive_o    (link_alive_o),
    .tx_drained_o    (tx_drained_o)
  );

endmodule

/* sv/hdufb_checker.sv */
// port-level checks for the frame buffer and their binding
module hdufb_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic                               tx_valid_o,
  input logic [7:0]                         tx_byte_o,
  input logic                               driver_enable_o,
  input logic                               frame_ready_o,
  input logic                               short_frame_o,
  input logic [6:0]                         rx_count_o,
  input logic                               tx_drained_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_idle_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tx_valid_o |-> tx_byte_o == 8'd0)
    else $error("tx byte nonzero without emit");

  a_drained_driver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tx_drained_o |-> driver_enable_o)
    else $error("drained while driver low");

  a_ready_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_ready_o |-> rx_count_o != 7'd0)
    else $error("frame closed with no bytes");

  a_short_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && short_frame_o |-> rx_count_o != 7'd0)
    else $error("short flag with no bytes");

endmodule

bind halfduplex_uart_frame_buffer hdufb_checker u_hdufb_checker (.*);
